>>> hdl/pbgg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pbgg_pkg;

   // Geometry of the display cells and of the bar.
   localparam int PIXELS_PER_CELL = 6;
   localparam int MAX_BAR_CELLS   = 64;

   // Field widths of the request and result words.
   localparam int PROG_W  = 8;
   localparam int LEN_W   = 7;
   localparam int GLYPH_W = 3;
   localparam int CELL_W  = 6;

   // Packed word widths, padded to whole bytes.
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   // Internal widths derived from the geometry.
   localparam int MAX_TOTAL = MAX_BAR_CELLS * PIXELS_PER_CELL;
   localparam int TOTAL_W   = $clog2(MAX_TOTAL + 6);
   localparam int PROD_W    = $clog2(((2 ** PROG_W) - 1) * MAX_TOTAL + 1);
   localparam int BITCNT_W  = $clog2(PROD_W);

   // Glyph codes.
   localparam logic [GLYPH_W-1:0] EMPTY_GLYPH = 3'd0;
   localparam logic [GLYPH_W-1:0] FULL_GLYPH  = 3'd5;

   // A cell counts as full once five pixels past its start are covered.
   localparam int FULL_OFFSET = 5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

>>> hdl/progress_bar_glyph_generator_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Progress bar glyph generator. Each request word carries a progress value, a
// maximum and a bar length in character cells; the block answers with one
// result word per cell, cell 0 first, holding the custom glyph code for that
// cell (0 empty, 1 to 4 partial, 5 full) and its index, with tlast on the final
// cell. The filled pixel count is progress * length * 6 / maximum, divided
// exactly and clamped to the full bar; a zero maximum draws a full bar, a zero
// length produces no result words, and lengths above 64 are treated as 64.
// A request goes through these steps in order: accept, multiply, then the
// bit-serial restoring divider, which resolves one quotient bit per cycle,
// and then the cell words, one per cell. A zero maximum bypasses the divider.
// The block handles one request at a time and holds req_tready low until the
// last cell word has been taken.
module progress_bar_glyph_generator_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // req_tdata fields, lowest bit first: progress[7:0], max_progress[15:8],
   // bar_length[22:16], zero padding[23].
   input  wire logic [pbgg_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // rsp_tdata fields, lowest bit first: glyph_code[2:0], cell_index[8:3],
   // zero padding[15:9]. The last_cell field travels as rsp_tlast.
   output logic [pbgg_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready
);

   import pbgg_pkg::*;

   // Request fields.
   logic [PROG_W-1:0] req_progress;
   logic [PROG_W-1:0] req_max;
   logic [LEN_W-1:0]  req_length;
   logic [LEN_W-1:0]  len_sat;

   assign req_progress = req_tdata[PROG_W-1:0];
   assign req_max      = req_tdata[2*PROG_W-1:PROG_W];
   assign req_length   = req_tdata[2*PROG_W+LEN_W-1:2*PROG_W];

   // Lengths beyond the largest bar saturate.
   assign len_sat = (req_length > LEN_W'(MAX_BAR_CELLS)) ? LEN_W'(MAX_BAR_CELLS) : req_length;

   // Control state.
   state_type state_ff, state_in;

   // Datapath registers.
   logic [PROG_W-1:0]   prog_ff,  prog_in;
   logic [PROG_W-1:0]   maxp_ff,  maxp_in;
   logic [LEN_W-1:0]    len_ff,   len_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [PROD_W-1:0]   quo_ff,   quo_in;
   logic [PROG_W-1:0]   rem_ff,   rem_in;
   logic [BITCNT_W-1:0] bit_ff,   bit_in;
   logic [TOTAL_W-1:0]  count_ff, count_in;
   logic [CELL_W-1:0]   cell_ff,  cell_in;
   logic [TOTAL_W-1:0]  start_ff, start_in;

   logic req_fire;
   logic rsp_fire;
   logic last_cell;

   // Divider step: shift in the next dividend bit and try to subtract.
   logic [PROG_W:0]   rem_shift;
   logic [PROG_W:0]   rem_diff;
   logic              quo_bit;
   logic [PROD_W-1:0] quo_step;

   assign rem_shift = {rem_ff, quo_ff[PROD_W-1]};
   assign rem_diff  = rem_shift - {1'b0, maxp_ff};
   assign quo_bit   = (rem_shift >= {1'b0, maxp_ff});
   assign quo_step  = {quo_ff[PROD_W-2:0], quo_bit};

   // Glyph selection for the current cell. A partial cell's code is the
   // count minus the cell's first pixel, which equals count mod the cell
   // width because the start is a multiple of it and the difference is small.
   logic [TOTAL_W-1:0] pix_left;
   logic [GLYPH_W-1:0] glyph;

   assign pix_left = count_ff - start_ff;

   always_comb begin
      if ((start_ff + TOTAL_W'(FULL_OFFSET)) <= count_ff) begin
         glyph = FULL_GLYPH;
      end else if (start_ff > count_ff) begin
         glyph = EMPTY_GLYPH;
      end else begin
         glyph = pix_left[GLYPH_W-1:0];
      end
   end

   assign last_cell = ({1'b0, cell_ff} == (len_ff - LEN_W'(1)));
   assign req_fire  = req_tvalid && req_tready;
   assign rsp_fire  = rsp_tvalid && rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && (len_sat != '0)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (maxp_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (bit_ff == '0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_tready && last_cell) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
            rsp_tvalid = 1'b0;
         end
      endcase
   end

   assign rsp_tdata = {{(RSP_DATA_W - GLYPH_W - CELL_W){1'b0}}, cell_ff, glyph};
   assign rsp_tlast = last_cell;

   // Datapath next values.
   always_comb begin
      prog_in  = prog_ff;
      maxp_in  = maxp_ff;
      len_in   = len_ff;
      total_in = total_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      bit_in   = bit_ff;
      count_in = count_ff;
      cell_in  = cell_ff;
      start_in = start_ff;

      if (req_fire) begin
         prog_in  = req_progress;
         maxp_in  = req_max;
         len_in   = len_sat;
         total_in = TOTAL_W'(len_sat) * TOTAL_W'(PIXELS_PER_CELL);
         cell_in  = '0;
         start_in = '0;
      end

      if (state_ff == ST_MUL) begin
         quo_in   = PROD_W'(prog_ff) * PROD_W'(total_ff);
         rem_in   = '0;
         bit_in   = BITCNT_W'(PROD_W - 1);
         // A zero maximum draws the whole bar.
         count_in = total_ff;
      end

      if (state_ff == ST_DIV) begin
         quo_in = quo_step;
         rem_in = quo_bit ? rem_diff[PROG_W-1:0] : rem_shift[PROG_W-1:0];
         bit_in = bit_ff - BITCNT_W'(1);
         if (bit_ff == '0) begin
            // Progress above the maximum cannot overfill the bar.
            if (quo_step > PROD_W'(total_ff)) begin
               count_in = total_ff;
            end else begin
               count_in = quo_step[TOTAL_W-1:0];
            end
         end
      end

      if (rsp_fire && !last_cell) begin
         cell_in  = cell_ff + CELL_W'(1);
         start_in = start_ff + TOTAL_W'(PIXELS_PER_CELL);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      prog_ff  <= prog_in;
      maxp_ff  <= maxp_in;
      len_ff   <= len_in;
      total_ff <= total_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      bit_ff   <= bit_in;
      count_ff <= count_in;
      cell_ff  <= cell_in;
      start_ff <= start_in;
   end

`ifndef SYNTHESIS
   // More cells follow a word that is not the last one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_tlast |=> rsp_tvalid)
      else $error("bar ended before its last cell");

   // The block is free for a new request right after the last cell is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_tlast |=> req_tready && !rsp_tvalid)
      else $error("block not idle after last cell");

   // A request with cells goes through the multiply before any result.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && (len_sat != '0) |=> !req_tready && !rsp_tvalid)
      else $error("request skipped the multiply cycle");

   // Glyph codes never exceed the full glyph.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[GLYPH_W-1:0] <= FULL_GLYPH))
      else $error("glyph code out of range");
`endif

endmodule

`default_nettype wire

>>> dv/pbgg_glyph_checker.sv
`timescale 1ns / 1ps

// Watches both streams of the glyph generator, works out the cell words each
// accepted request must produce and compares every accepted result word
// against the oldest outstanding one.
module pbgg_glyph_checker
   import pbgg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  rsp_tlast,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output int                         fail_count,
   output int                         cells_pending,
   output int                         requests_seen,
   output int                         cells_checked
);

   typedef struct packed {
      logic [GLYPH_W-1:0] glyph_code;
      logic [CELL_W-1:0]  cell_index;
      logic               last_cell;
   } bar_cell_type;

   bar_cell_type bar_cells_due[$];
   int           mismatches;
   int           requests_total;
   int           cells_total;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: mismatch on %s: got %0d, wanted %0d", $time, what, got, want);
      mismatches++;
   endtask

   // Splits the filled pixel count over the cells of the bar.
   task automatic predict_bar_cells(input logic [REQ_DATA_W-1:0] word);
      int           progress;
      int           max_progress;
      int           cells;
      int           total_px;
      int           filled_px;
      int           first_px;
      bar_cell_type next_cell;
      progress     = int'(word[PROG_W-1:0]);
      max_progress = int'(word[2*PROG_W-1:PROG_W]);
      cells        = int'(word[2*PROG_W +: LEN_W]);
      if (cells > MAX_BAR_CELLS)
         cells = MAX_BAR_CELLS;
      if (cells == 0)
         return;
      total_px = cells * PIXELS_PER_CELL;
      // A zero maximum means a complete bar.
      if (max_progress == 0)
         filled_px = total_px;
      else
         filled_px = (progress * total_px) / max_progress;
      if (filled_px > total_px)
         filled_px = total_px;
      for (int i = 0; i < cells; i++) begin
         first_px = i * PIXELS_PER_CELL;
         if (first_px + FULL_OFFSET <= filled_px)
            next_cell.glyph_code = FULL_GLYPH;
         else if (first_px > filled_px)
            next_cell.glyph_code = EMPTY_GLYPH;
         else
            next_cell.glyph_code = GLYPH_W'(filled_px % PIXELS_PER_CELL);
         next_cell.cell_index = CELL_W'(i);
         next_cell.last_cell  = (i == cells - 1);
         bar_cells_due.push_back(next_cell);
      end
   endtask

   always @(posedge clock) begin
      bar_cell_type due;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_bar_cells(req_tdata);
            requests_total++;
         end
         if (rsp_tvalid && rsp_tready) begin
            cells_total++;
            if (bar_cells_due.size() == 0) begin
               report_mismatch("unexpected cell word, index",
                               int'(rsp_tdata[GLYPH_W +: CELL_W]), -1);
            end else begin
               due = bar_cells_due.pop_front();
               if (rsp_tdata[GLYPH_W-1:0] !== due.glyph_code)
                  report_mismatch("glyph_code", int'(rsp_tdata[GLYPH_W-1:0]),
                                  int'(due.glyph_code));
               if (rsp_tdata[GLYPH_W +: CELL_W] !== due.cell_index)
                  report_mismatch("cell_index", int'(rsp_tdata[GLYPH_W +: CELL_W]),
                                  int'(due.cell_index));
               if (rsp_tlast !== due.last_cell)
                  report_mismatch("last_cell", int'(rsp_tlast), int'(due.last_cell));
            end
         end
      end
      fail_count    <= mismatches;
      cells_pending <= bar_cells_due.size();
      requests_seen <= requests_total;
      cells_checked <= cells_total;
   end

endmodule

>>> dv/tb_progress_bar_glyph_generator_top.sv
`timescale 1ns / 1ps

// Testbench top for the progress bar glyph generator. It only makes stimulus
// and gives the verdict; prediction and comparison live in the checker that
// sits beside the block and watches both streams.
module tb_progress_bar_glyph_generator_top;
   import pbgg_pkg::*;

   // The receiver stalls this long once, while the sender keeps offering words.
   localparam int LONG_HOLD_CYCLES = 300;
   // Wait after the last cell word for any stray word to show.
   localparam int DRAIN_CYCLES     = 120;
   localparam int RANDOM_ITEMS     = 220;
   // Limit on the length of the whole run, in nanoseconds.
   localparam int TIMEOUT_NS       = 10_000_000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;

   int fail_count;
   int cells_pending;
   int requests_seen;
   int cells_checked;

   // Shared between the two sides: whether random waits are drawn at all, and
   // a request from the stimulus for the receiver to hold off for a long time.
   bit idling_on         = 1'b1;
   bit long_hold_pending = 1'b0;
   int quiet_items       = 0;

   progress_bar_glyph_generator_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   pbgg_glyph_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tdata     (req_tdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .fail_count    (fail_count),
      .cells_pending (cells_pending),
      .requests_seen (requests_seen),
      .cells_checked (cells_checked)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Safety net: a hung handshake or a missing cell word ends up here.
   initial begin
      #(TIMEOUT_NS);
      $display("Timed out with %0d cell words still outstanding.", cells_pending);
      $display("FAIL");
      $finish;
   end

   // With idling on, half of the words go without a wait and the rest draw a
   // random wait, so gaps land on every phase of multiply, divide and emit loop.
   function automatic int draw_wait();
      if (!idling_on || $urandom_range(0, 1) == 0)
         return 0;
      return $urandom_range(0, 18);
   endfunction

   // The padding bit on top of req_tdata is always driven to zero.
   function automatic logic [REQ_DATA_W-1:0] pack_request(input int progress,
                                                          input int max_progress,
                                                          input int bar_length);
      return {1'b0, LEN_W'(bar_length), PROG_W'(max_progress), PROG_W'(progress)};
   endfunction

   // Random requests are mostly well formed: a nonzero maximum, progress up to
   // that maximum and short bars. The rest covers zero maximum, overrun, zero
   // length and lengths that saturate at the bar limit.
   function automatic logic [REQ_DATA_W-1:0] random_request();
      int max_progress;
      int progress;
      int bar_length;
      int pick;
      pick = $urandom_range(0, 99);
      max_progress = (pick < 5) ? 0 : $urandom_range(1, 255);
      pick = $urandom_range(0, 99);
      if (pick < 70)
         progress = $urandom_range(0, max_progress);
      else if (pick < 90)
         progress = $urandom_range(0, 255);
      else
         progress = max_progress;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         bar_length = $urandom_range(1, 12);
      else if (pick < 85)
         bar_length = $urandom_range(13, 40);
      else if (pick < 93)
         bar_length = $urandom_range(41, 64);
      else if (pick < 97)
         bar_length = $urandom_range(65, 127);
      else
         bar_length = 0;
      return pack_request(progress, max_progress, bar_length);
   endfunction

   // Offers one request word and returns at the edge where it is taken. When no
   // wait is drawn, tvalid simply stays high and only the data changes, so that
   // tvalid never gets two assignments in one time step.
   task automatic send_request(input logic [REQ_DATA_W-1:0] word);
      int wait_cycles;
      wait_cycles = draw_wait();
      if (wait_cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (wait_cycles) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Receiver: a fresh stall for every cell word, plus one long hold-off on
   // request so the block fills up and keeps req_tready low.
   initial begin : result_side
      int stall_cycles;
      forever begin
         if (long_hold_pending) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_pending = 1'b0;
         end
         stall_cycles = draw_wait();
         if (stall_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall_cycles) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin : request_side
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: field extremes and the special cases.
      send_request(pack_request(0, 0, 0));          // zero length, no words
      send_request(pack_request(0, 0, 1));          // zero maximum draws full
      send_request(pack_request(255, 0, 64));       // zero maximum, longest bar
      send_request(pack_request(0, 255, 64));       // empty bar
      send_request(pack_request(255, 255, 64));     // complete bar
      send_request(pack_request(255, 1, 64));       // progress far above maximum
      send_request(pack_request(200, 100, 10));     // overrun is clamped
      send_request(pack_request(1, 255, 64));       // a single filled pixel
      send_request(pack_request(1, 6, 1));          // partial code 1
      send_request(pack_request(4, 6, 1));          // partial code 4
      send_request(pack_request(5, 6, 1));          // five pixels make a full cell
      send_request(pack_request(1, 2, 2));          // count on a cell's first pixel
      send_request(pack_request(128, 255, 127));    // length saturates
      send_request(pack_request(77, 200, 65));      // just above the bar limit
      send_request(pack_request(255, 254, 64));
      send_request(pack_request(127, 128, 100));
      send_request(pack_request(8'hAA, 8'h55, 7'h2A));
      send_request(pack_request(8'h55, 8'hAA, 7'h55));
      send_request(pack_request(3, 7, 33));
      send_request(pack_request(100, 200, 1));
      send_request(pack_request(0, 1, 0));

      // Random part. The first stretch runs with no idling on either side.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idling_on = (n >= 60);
         if (!idling_on)
            quiet_items++;
         if (n == 120)
            long_hold_pending = 1'b1;
         send_request(random_request());
      end
      req_tvalid <= 1'b0;

      // Drain: wait for the last cell word, then give the block time to show
      // any stray word before the verdict.
      do @(posedge clock); while (cells_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests (%0d with both sides idle-free) and checked %0d cell words.",
               requests_seen, quiet_items, cells_checked);
      $display("The receiver held off once for %0d cycles while requests kept coming.",
               LONG_HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches found.", fail_count);
         $display("FAIL");
      end
      $finish;
   end

endmodule
